// ----- src/sclt_pkg.sv -----
package sclt_pkg;

  typedef enum logic [2:0] {
    KIND_WORD    = 3'd0,
    KIND_PIPE    = 3'd1,
    KIND_OUT     = 3'd2,
    KIND_APPEND  = 3'd3,
    KIND_IN      = 3'd4,
    KIND_HEREDOC = 3'd5
  } token_kind_e;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_PIPE   = 8'h7c;

  localparam logic [11:0] ORD_MAX = 12'hfff;

  typedef struct packed {
    logic [12:0] length;
    logic [11:0] start;
    logic [11:0] ordinal;
    token_kind_e kind;
    logic        last;
  } token_t;

  // tokens produced by one byte: count is 0, 1 or 2, first goes out first
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

endpackage

// ----- src/sclt_lexer.sv -----
module sclt_lexer
  import sclt_pkg::*;
#(
  parameter int unsigned MAX_LINE = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] char_i,
  output push_t      push_o
);

  localparam int unsigned PW = $clog2(MAX_LINE);
  localparam logic [PW-1:0] POS_LAST = PW'(MAX_LINE - 1);

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_WORD  = 3'd1,
    MODE_QUOTE = 3'd2,
    MODE_GT    = 3'd3,
    MODE_LT    = 3'd4
  } mode_e;

  mode_e         mode_q, mode_d;
  logic          dquote_q, dquote_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] begin_q, begin_d;
  logic [11:0]   ord_q, ord_d;

  logic          is_nul, is_blank, ends_word;
  logic [PW:0]   span;
  logic          close_v, open_ok, pipe_v;
  token_kind_e   close_kind;
  logic [PW:0]   close_len;
  logic [PW:0]   len_fix;
  logic [31:0]   len_wide, begin_wide, pos_wide;
  logic [11:0]   ord_inc;
  logic [12:0]   ord_sum2;
  logic [1:0]    n_tok;
  token_t        close_tok, pipe_tok;

  always_comb begin
    is_nul    = (char_i == CH_NUL);
    is_blank  = (char_i == CH_SPACE) || ((char_i >= CH_TAB) && (char_i <= CH_CR));
    ends_word = is_nul || is_blank || (char_i == CH_PIPE) || (char_i == CH_GT) ||
                (char_i == CH_LT);
    span      = {1'b0, pos_q} - {1'b0, begin_q};

    close_v    = 1'b0;
    close_kind = KIND_WORD;
    close_len  = span;
    open_ok    = 1'b0;
    mode_d     = mode_q;
    dquote_d   = dquote_q;
    begin_d    = begin_q;
    pipe_v     = 1'b0;

    unique case (mode_q)
      MODE_WORD: begin
        if (ends_word) begin
          close_v = 1'b1;
          mode_d  = MODE_IDLE;
          open_ok = !is_nul;
        end
      end
      MODE_QUOTE: begin
        if (is_nul) begin
          close_v = 1'b1;
          mode_d  = MODE_IDLE;
        end else if (char_i == (dquote_q ? CH_DQUOTE : CH_SQUOTE)) begin
          close_v   = 1'b1;
          close_len = span + (PW+1)'(1);
          mode_d    = MODE_IDLE;
        end
      end
      MODE_GT, MODE_LT: begin
        mode_d  = MODE_IDLE;
        close_v = 1'b1;
        if (char_i == ((mode_q == MODE_GT) ? CH_GT : CH_LT)) begin
          close_kind = (mode_q == MODE_GT) ? KIND_APPEND : KIND_HEREDOC;
          close_len  = (PW+1)'(2);
        end else begin
          close_kind = (mode_q == MODE_GT) ? KIND_OUT : KIND_IN;
          close_len  = (PW+1)'(1);
          open_ok    = !is_nul;
        end
      end
      default: begin
        mode_d  = MODE_IDLE;
        open_ok = !is_nul;
      end
    endcase

    if (open_ok && !is_blank) begin
      begin_d = pos_q;
      if (char_i == CH_PIPE) begin
        pipe_v = 1'b1;
      end else if (char_i == CH_GT) begin
        mode_d = MODE_GT;
      end else if (char_i == CH_LT) begin
        mode_d = MODE_LT;
      end else if ((char_i == CH_SQUOTE) || (char_i == CH_DQUOTE)) begin
        mode_d   = MODE_QUOTE;
        dquote_d = (char_i == CH_DQUOTE);
      end else begin
        mode_d = MODE_WORD;
      end
    end

    // a length that comes out as zero near the line limit is raised to one
    len_fix    = (close_len == '0) ? (PW+1)'(1) : close_len;
    len_wide   = 32'(len_fix);
    begin_wide = 32'(begin_q);
    pos_wide   = 32'(pos_q);

    ord_inc  = (ord_q == ORD_MAX) ? ord_q : ord_q + 12'd1;
    ord_sum2 = {1'b0, ord_q} + 13'd2;

    close_tok.kind    = close_kind;
    close_tok.ordinal = ord_q;
    close_tok.start   = begin_wide[11:0];
    close_tok.length  = len_wide[12:0];
    close_tok.last    = !pipe_v;

    pipe_tok.kind    = KIND_PIPE;
    pipe_tok.ordinal = close_v ? ord_inc : ord_q;
    pipe_tok.start   = pos_wide[11:0];
    pipe_tok.length  = 13'd1;
    pipe_tok.last    = 1'b1;

    n_tok = {1'b0, close_v} + {1'b0, pipe_v};

    push_o.count  = take_i ? n_tok : 2'd0;
    push_o.first  = close_v ? close_tok : pipe_tok;
    push_o.second = pipe_tok;

    unique case (n_tok)
      2'd0:    ord_d = ord_q;
      2'd1:    ord_d = ord_inc;
      default: ord_d = ord_sum2[12] ? ORD_MAX : ord_sum2[11:0];
    endcase

    pos_d = (pos_q != POS_LAST) ? pos_q + PW'(1) : pos_q;

    // end of line clears the line state
    if (is_nul) begin
      mode_d   = MODE_IDLE;
      dquote_d = 1'b0;
      pos_d    = '0;
      begin_d  = '0;
      ord_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      dquote_q <= 1'b0;
      pos_q    <= '0;
      begin_q  <= '0;
      ord_q    <= '0;
    end else if (take_i) begin
      mode_q   <= mode_d;
      dquote_q <= dquote_d;
      pos_q    <= pos_d;
      begin_q  <= begin_d;
      ord_q    <= ord_d;
    end
  end

`ifndef SYNTHESIS
  a_nul_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && (char_i == CH_NUL) |=> (pos_q == '0) && (ord_q == '0) && (mode_q == MODE_IDLE))
    else $error("line state not cleared at end of line");

  a_begin_le_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    begin_q <= pos_q)
    else $error("token start beyond current position");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.count == 2'd2 |-> (push_o.first.kind != KIND_PIPE) &&
                             (push_o.second.kind == KIND_PIPE) && !push_o.first.last)
    else $error("two tokens from one byte in wrong form");
`endif

endmodule

// ----- src/sclt_outq.sv -----
module sclt_outq
  import sclt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  input  logic   ready_i,
  output logic   valid_o,
  output token_t head_o,
  output logic   room_o
);

  token_t     q_q [3];
  token_t     q_d [3];
  token_t     base [3];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] after;
  logic       pop;

  always_comb begin
    pop     = (cnt_q != 2'd0) && ready_i;
    after   = cnt_q - {1'b0, pop};
    base[0] = pop ? q_q[1] : q_q[0];
    base[1] = pop ? q_q[2] : q_q[1];
    base[2] = q_q[2];
    for (int i = 0; i < 3; i++) begin
      q_d[i] = base[i];
      if ((push_i.count != 2'd0) && (after == 2'(i))) begin
        q_d[i] = push_i.first;
      end
      if ((push_i.count == 2'd2) && ((after + 2'd1) == 2'(i))) begin
        q_d[i] = push_i.second;
      end
    end
    cnt_d = after + push_i.count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = q_q[0];
  assign room_o  = (cnt_q <= 2'd1);

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> cnt_q <= 2'd1)
    else $error("token queue overflow");

  a_count_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd3)
    else $error("more than two tokens from one byte");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && (push_i.count == 2'd0) |=> cnt_q == $past(cnt_q) - 2'd1)
    else $error("queue count lost on transfer");
`endif

endmodule

// ----- src/shell_command_line_tokenizer.sv -----
// Streaming shell command-line lexer. Each input transfer carries one byte of a line; byte 0 ends
// the line, flushes a pending token and restarts offsets and ordinals at zero. Tokens (words,
// quoted words, pipes, >, >>, <, <<) leave as one transfer each with kind, ordinal, start offset
// and length; tlast marks the last token caused by one byte. A single > or < comes out only when
// the next byte arrives. The lexer takes one byte per cycle while s_axis_tready is high, and its
// tokens enter a registered three-entry token queue when the byte is taken. The queue drains one
// token per cycle while m_axis_tready is high; s_axis_tready drops while two or more tokens wait,
// so a byte that yields two tokens (word or redirect followed by a pipe) may delay the next byte.
module shell_command_line_tokenizer
  import sclt_pkg::*;
#(
  parameter int unsigned MAX_LINE = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // token_kind, token_ordinal, token_start, token_length
  output logic        m_axis_tlast    // last_of_run
);

  push_t  push;
  token_t head;
  logic   room;
  logic   take;

  assign take          = s_axis_tvalid && room;
  assign s_axis_tready = room;

  sclt_lexer #(
    .MAX_LINE(MAX_LINE)
  ) u_lexer (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .take_i(take),
    .char_i(s_axis_tdata),
    .push_o(push)
  );

  sclt_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .ready_i(m_axis_tready),
    .valid_o(m_axis_tvalid),
    .head_o (head),
    .room_o (room)
  );

  assign m_axis_tdata = {head.length, head.start, head.ordinal, head.kind};
  assign m_axis_tlast = head.last;

endmodule

// ----- bench/tokenizer_checker.sv -----
module tokenizer_checker
  import sclt_pkg::*;
#(
  parameter int unsigned MAX_LINE = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [7:0]  s_data_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [39:0] m_data_i,
  input  logic        m_last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    LX_IDLE,
    LX_WORD,
    LX_QUOTE,
    LX_GT,
    LX_LT
  } lex_mode_e;

  lex_mode_e lex_mode;
  logic      quote_dq;
  int        line_pos;
  int        tok_begin;
  int        tok_count;

  token_t    step_tok [2];
  int        step_n;
  token_t    pending_tokens [$];

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit ends_word(input logic [7:0] c);
    return c == CH_NUL || is_blank(c) || c == CH_PIPE || c == CH_GT || c == CH_LT;
  endfunction

  task emit_token(input token_kind_e kind, input int start, input int len);
    if (step_n < 2) begin
      if (len == 0) begin
        len = 1;
      end
      step_tok[step_n].kind    = kind;
      step_tok[step_n].ordinal = tok_count[11:0];
      step_tok[step_n].start   = start[11:0];
      step_tok[step_n].length  = len[12:0];
      step_tok[step_n].last    = 1'b0;
      if (tok_count < int'(ORD_MAX)) begin
        tok_count++;
      end
      step_n++;
    end
  endtask

  // a nonzero byte arriving between tokens
  task open_token(input logic [7:0] c);
    if (!is_blank(c)) begin
      tok_begin = line_pos;
      if (c == CH_PIPE) begin
        emit_token(KIND_PIPE, line_pos, 1);
      end else if (c == CH_GT) begin
        lex_mode = LX_GT;
      end else if (c == CH_LT) begin
        lex_mode = LX_LT;
      end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
        lex_mode = LX_QUOTE;
        quote_dq = (c == CH_DQUOTE);
      end else begin
        lex_mode = LX_WORD;
      end
    end
  endtask

  task clear_line;
    lex_mode  = LX_IDLE;
    quote_dq  = 1'b0;
    line_pos  = 0;
    tok_begin = 0;
    tok_count = 0;
  endtask

  task lex_byte(input logic [7:0] c);
    logic was_gt;
    step_n = 0;
    case (lex_mode)
      LX_WORD: begin
        if (ends_word(c)) begin
          emit_token(KIND_WORD, tok_begin, line_pos - tok_begin);
          lex_mode = LX_IDLE;
          if (c != CH_NUL) begin
            open_token(c);
          end
        end
      end
      LX_QUOTE: begin
        if (c == CH_NUL) begin
          emit_token(KIND_WORD, tok_begin, line_pos - tok_begin);
          lex_mode = LX_IDLE;
        end else if (c == (quote_dq ? CH_DQUOTE : CH_SQUOTE)) begin
          emit_token(KIND_WORD, tok_begin, line_pos - tok_begin + 1);
          lex_mode = LX_IDLE;
        end
      end
      LX_GT, LX_LT: begin
        was_gt = (lex_mode == LX_GT);
        lex_mode = LX_IDLE;
        if (c == (was_gt ? CH_GT : CH_LT)) begin
          emit_token(was_gt ? KIND_APPEND : KIND_HEREDOC, tok_begin, 2);
        end else begin
          emit_token(was_gt ? KIND_OUT : KIND_IN, tok_begin, 1);
          if (c != CH_NUL) begin
            open_token(c);
          end
        end
      end
      default: begin
        lex_mode = LX_IDLE;
        if (c != CH_NUL) begin
          open_token(c);
        end
      end
    endcase

    if (step_n > 0) begin
      step_tok[step_n - 1].last = 1'b1;
    end
    for (int i = 0; i < step_n; i++) begin
      pending_tokens.push_back(step_tok[i]);
    end

    if (c == CH_NUL) begin
      clear_line();
    end else if (line_pos < int'(MAX_LINE) - 1) begin
      line_pos++;
    end
  endtask

  task compare_field(input string field_name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field_name, want, got);
      fail_count_o++;
    end
  endtask

  task check_token;
    token_t want;
    if (pending_tokens.size() == 0) begin
      $error("unexpected token: kind %0d start %0d length %0d",
             m_data_i[2:0], m_data_i[26:15], m_data_i[39:27]);
      fail_count_o++;
    end else begin
      want = pending_tokens.pop_front();
      compare_field("token_kind", int'(want.kind), int'(m_data_i[2:0]));
      compare_field("token_ordinal", int'(want.ordinal), int'(m_data_i[14:3]));
      compare_field("token_start", int'(want.start), int'(m_data_i[26:15]));
      compare_field("token_length", int'(want.length), int'(m_data_i[39:27]));
      compare_field("last_of_run", int'(want.last), int'(m_last_i));
      checked_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_line();
      pending_tokens.delete();
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      if (s_valid_i && s_ready_i) begin
        lex_byte(s_data_i);
      end
      if (m_valid_i && m_ready_i) begin
        check_token();
      end
    end
    pending_o = pending_tokens.size();
  end

endmodule

// ----- bench/tb_top.sv -----
module tb_top
  import sclt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LINE    = 4096;
  localparam int          HOLD_CYCLES = 300;
  localparam int          STALL_LIMIT = 2000;
  localparam int          RANDOM_BYTES = 350;
  localparam int          LONG_PIPES  = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  int fail_count;
  int pending_count;
  int tokens_checked;

  int bytes_sent;
  int lines_sent;
  int idle_cycles;
  bit idle_tx;
  bit hold_req;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  shell_command_line_tokenizer #(
    .MAX_LINE(MAX_LINE)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  tokenizer_checker #(
    .MAX_LINE(MAX_LINE)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .m_last_i     (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending_count),
    .checked_o    (tokens_checked)
  );

  // nothing transferred for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("shell_command_line_tokenizer test failed");
      $finish;
    end
  end

  // token receiver
  initial begin
    int stall;
    int stretch;
    bit rx_idle;
    int r;
    stall   = 0;
    stretch = 0;
    rx_idle = 1'b1;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (stretch == 0) begin
          stretch = $urandom_range(50, 300);
          rx_idle = ($urandom_range(0, 3) != 0);
        end
        stretch--;
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          stall--;
        end else begin
          m_axis_tready <= 1'b1;
          if (rx_idle) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
              stall = 0;
            end else if (r < 94) begin
              stall = $urandom_range(1, 3);
            end else begin
              stall = $urandom_range(10, 50);
            end
          end
        end
      end
    end
  end

  function automatic int tx_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_tx || r < 65) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic put_byte(input logic [7:0] c);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    if (c == CH_NUL) begin
      lines_sent++;
    end
    @(negedge clk_i);
    gap = tx_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic put_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put_byte(s[i]);
    end
  endtask

  task automatic wait_drained;
    while (pending_count != 0) begin
      @(negedge clk_i);
    end
  endtask

  function automatic logic [7:0] blank_char();
    int r;
    r = $urandom_range(7, 13);
    return (r < 9) ? CH_SPACE : 8'(r);
  endfunction

  function automatic logic [7:0] word_char(input bit first);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR) || c == CH_PIPE ||
               c == CH_GT || c == CH_LT ||
               (first && (c == CH_DQUOTE || c == CH_SQUOTE)));
    return c;
  endfunction

  function automatic logic [7:0] quoted_char(input logic [7:0] q);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == q);
    return c;
  endfunction

  function automatic logic [7:0] noise_char();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      10:      return CH_PIPE;
      11:      return CH_GT;
      12:      return CH_LT;
      13:      return CH_DQUOTE;
      14:      return CH_SQUOTE;
      15:      return CH_SPACE;
      16:      return 8'($urandom_range(9, 13));
      17:      return 8'hff;
      18:      return CH_NUL;
      19:      return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic random_token(input bit last_one);
    int r;
    int n;
    logic [7:0] q;
    r = $urandom_range(0, 11);
    if (r < 5) begin
      n = $urandom_range(1, 6);
      put_byte(word_char(1'b1));
      for (int i = 1; i < n; i++) begin
        put_byte(word_char(1'b0));
      end
    end else if (r < 8) begin
      q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
      n = $urandom_range(0, 6);
      put_byte(q);
      for (int i = 0; i < n; i++) begin
        put_byte(quoted_char(q));
      end
      // an open quote may run to the end of the line
      if (!(last_one && $urandom_range(0, 3) == 0)) begin
        put_byte(q);
      end
    end else if (r == 8) begin
      put_byte(CH_GT);
      if ($urandom_range(0, 1)) begin
        put_byte(CH_GT);
      end
    end else if (r == 9) begin
      put_byte(CH_LT);
      if ($urandom_range(0, 1)) begin
        put_byte(CH_LT);
      end
    end else begin
      put_byte(CH_PIPE);
    end
  endtask

  task automatic random_line;
    int n;
    idle_tx = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 9) < 2) begin
      n = $urandom_range(1, 24);
      for (int i = 0; i < n; i++) begin
        put_byte(noise_char());
      end
    end else begin
      repeat ($urandom_range(0, 2)) put_byte(blank_char());
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        random_token(i == n - 1);
        repeat ($urandom_range(0, 3)) put_byte(blank_char());
      end
    end
    put_byte(CH_NUL);
  endtask

  initial begin
    int start_bytes;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = CH_NUL;
    hold_req      = 1'b0;
    idle_tx       = 1'b1;
    bytes_sent    = 0;
    lines_sent    = 0;
    idle_cycles   = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty line, quotes, heredoc, unterminated quote
    put_byte(CH_NUL);
    put_string("'a b'x<<\"q|");
    put_byte(CH_NUL);
    // top byte, redirect then pipe, quote inside a word, blanks, append, trailing blank
    put_byte(8'hff);
    put_string(">|");
    put_byte(8'h01);
    put_byte(CH_DQUOTE);
    put_byte(CH_TAB);
    put_byte(CH_CR);
    put_string(" <z>> ");
    put_byte(CH_NUL);

    // receiver holds off while two-token bytes keep coming
    idle_tx  = 1'b0;
    hold_req = 1'b1;
    put_string("a|b|c|d|e|f|g|h|i|j|");
    put_byte(CH_NUL);
    wait_drained();

    // back-to-back pipes, one token per byte
    idle_tx = 1'b0;
    repeat (LONG_PIPES) put_byte(CH_PIPE);
    put_string("abc|");
    put_byte(CH_NUL);

    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      random_line();
    end
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (20) @(negedge clk_i);

    $display("sent %0d bytes in %0d lines, %0d tokens checked", bytes_sent, lines_sent,
             tokens_checked);
    $display("included a long receiver hold-off and a %0d-byte line of back-to-back pipes",
             LONG_PIPES + 5);
    if (fail_count == 0 && pending_count == 0) begin
      $display("shell_command_line_tokenizer test passed");
    end else begin
      $display("shell_command_line_tokenizer test failed");
    end
    $finish;
  end

endmodule
